// ===== rtl/core/lfpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpl_pkg
// shared constants, parser phase codes and the pixel write record
// ----------------------------------------------------------------------------
package lfpl_pkg;

	localparam int NUM_COLUMNS    = 64;
	localparam int SCAN_MULTIPLEX = 16;
	localparam int NUM_ROWS       = 2 * SCAN_MULTIPLEX;

	localparam int ROW_W    = 6;
	localparam int COLUMN_W = 14;
	localparam int BYTE_W   = 8;

	localparam int PIX_ROW_W = 5;
	localparam int PIX_COL_W = 6;

	// tdata widths: one byte in, 35 bits of fields out padded to 40
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_FIELD_W = PIX_ROW_W + PIX_COL_W + 3 * BYTE_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic [ROW_W:0]    ROWS_LIM = (ROW_W + 1)'(NUM_ROWS);
	localparam logic [COLUMN_W:0] COLS_LIM = (COLUMN_W + 1)'(NUM_COLUMNS);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_RED   = 3'd2,
		PH_GREEN = 3'd3,
		PH_BLUE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic                 buffer_select;
		logic [PIX_ROW_W-1:0] pixel_row;
		logic [PIX_COL_W-1:0] pixel_column;
		logic [BYTE_W-1:0]    red;
		logic [BYTE_W-1:0]    green;
		logic [BYTE_W-1:0]    blue;
		logic                 pixel_valid;
		logic                 frame_done;
	} pix_write_t;

endpackage

// ===== rtl/core/lfpl_parser.sv =====
// ----------------------------------------------------------------------------
// lfpl_parser
// header and colour triple parsing, position tracking and buffer toggling
// ----------------------------------------------------------------------------
module lfpl_parser
	import lfpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              packet_start,
	output logic              has_result,
	output pix_write_t        result
);

	phase_t               phase_q, phase_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [COLUMN_W-1:0]  col_q, col_d;
	logic                 half_q, half_d;
	logic [BYTE_W-1:0]    red_q, red_d;
	logic [BYTE_W-1:0]    green_q, green_d;
	logic [BYTE_W-1:0]    hdr_q, hdr_d;

	logic [COLUMN_W:0]    col_inc;
	logic [ROW_W:0]       row_inc;
	logic                 in_frame;
	logic                 col_wrap;
	logic                 row_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			half_q  <= 1'b0;
			red_q   <= '0;
			green_q <= '0;
			hdr_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			col_q   <= col_d;
			half_q  <= half_d;
			red_q   <= red_d;
			green_q <= green_d;
			hdr_q   <= hdr_d;
		end
	end

	always_comb begin
		col_inc  = {1'b0, col_q} + (COLUMN_W + 1)'(1);
		row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
		in_frame = ({1'b0, row_q} < ROWS_LIM) && ({1'b0, col_q} < COLS_LIM);
		col_wrap = col_inc >= COLS_LIM;
		row_wrap = row_inc >= ROWS_LIM;

		phase_d    = phase_q;
		row_d      = row_q;
		col_d      = col_q;
		half_d     = half_q;
		red_d      = red_q;
		green_d    = green_q;
		hdr_d      = hdr_q;
		has_result = 1'b0;

		result.buffer_select = half_q;
		result.pixel_row     = in_frame ? row_q[PIX_ROW_W-1:0] : '0;
		result.pixel_column  = in_frame ? col_q[PIX_COL_W-1:0] : '0;
		result.red           = red_q;
		result.green         = green_q;
		result.blue          = byte_value;
		result.pixel_valid   = in_frame;
		result.frame_done    = col_wrap && row_wrap;

		if (packet_start) begin
			// a new header always wins, any partial triple is dropped
			hdr_d   = byte_value;
			phase_d = PH_HDR1;
		end else begin
			unique case (phase_q)
				PH_HDR1: begin
					row_d   = hdr_q[BYTE_W-1:2];
					col_d   = {hdr_q[5:0], byte_value};
					phase_d = PH_RED;
				end
				PH_RED: begin
					red_d   = byte_value;
					phase_d = PH_GREEN;
				end
				PH_GREEN: begin
					green_d = byte_value;
					phase_d = PH_BLUE;
				end
				PH_BLUE: begin
					has_result = 1'b1;
					phase_d    = PH_RED;
					if (col_wrap) begin
						col_d = '0;
						if (row_wrap) begin
							row_d  = '0;
							half_d = ~half_q;
						end else begin
							row_d = row_inc[ROW_W-1:0];
						end
					end else begin
						col_d = col_inc[COLUMN_W-1:0];
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/led_frame_packet_loader_top.sv =====
// ----------------------------------------------------------------------------
// led_frame_packet_loader_top
// turns a packet byte stream into pixel writes for a double frame buffer
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                        | tuser                   | tlast
//  s_axis   | in  | byte_value                   | packet_start            | -
//  m_axis   | out | row, column, red, green, blue| buffer_select, pix_valid| frame_done
//
//  one byte is taken every cycle unless a blue byte waits on a stalled m_axis
//  a blue byte gives one pixel write via input register, parse logic, result register
//  header and red/green bytes give no transaction on m_axis
//  a stalled m_axis holds its transaction; bytes that give no write still flow
//  reset clears parser state, write half and both valid flags
module led_frame_packet_loader_top
	import lfpl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // byte_value
	input  logic                   s_axis_tuser,  // packet_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pixel_row, pixel_column, red, green, blue
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // buffer_select, pixel_valid
	output logic                   m_axis_tlast   // frame_done
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	logic              out_valid_q;
	pix_write_t        out_q;

	logic              has_result;
	pix_write_t        result;
	logic              out_free;
	logic              advance;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata[BYTE_W-1:0];
			start_s1 <= s_axis_tuser;
		end
	end

	lfpl_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.byte_value   (byte_s1),
		.packet_start (start_s1),
		.has_result   (has_result),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_q.blue, out_q.green,
		out_q.red, out_q.pixel_column, out_q.pixel_row};
	assign m_axis_tuser  = {out_q.pixel_valid, out_q.buffer_select};
	assign m_axis_tlast  = out_q.frame_done;

endmodule

// ===== rtl/core/lfpl_checker.sv =====
// ----------------------------------------------------------------------------
// lfpl_checker
// port level checks on the pixel write stream of the loader
// ----------------------------------------------------------------------------
module lfpl_checker
	import lfpl_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input logic                   m_axis_tlast
);

	// half that the next write should target, flips after each completed frame
	logic half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
			half_q <= ~half_q;
		end
	end

	// stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("m_axis transaction changed while stalled");

	// an out of frame write carries a zero position
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[PIX_ROW_W+PIX_COL_W-1:0] == '0)
		else $error("out of frame write with non-zero position");

	// an in frame write that ends the frame sits on the last row and column
	a_done_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[1] |->
			m_axis_tdata[PIX_ROW_W-1:0] == PIX_ROW_W'(NUM_ROWS - 1)
			&& m_axis_tdata[PIX_ROW_W+PIX_COL_W-1:PIX_ROW_W] == PIX_COL_W'(NUM_COLUMNS - 1))
		else $error("frame done away from the last pixel");

	// the half flips right after a frame completes
	a_half_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] == half_q)
		else $error("buffer half out of step with completed frames");

endmodule

bind led_frame_packet_loader_top lfpl_checker u_lfpl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives packet bytes into the frame packet loader and checks every pixel
// write against an in-bench model of the header parse, position advance and
// double-buffer toggle; a directed table goes first, then random packets
// ----------------------------------------------------------------------------
module testbench;
	import lfpl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 750;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // byte_value
	logic                   s_axis_tuser;   // packet_start
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // pixel_row, pixel_column, red, green, blue
	logic [OUT_TUSER_W-1:0] m_axis_tuser;   // buffer_select, pixel_valid
	logic                   m_axis_tlast;   // frame_done

	led_frame_packet_loader_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	typedef struct {
		logic [7:0] value;
		logic       start;
		bit         typed;
		pix_write_t write;
	} stim_row_t;

	// typed writes only where the outcome is plain; the rest use the model
	stim_row_t directed_rows [26] = '{
		'{8'hAA, 1'b0, 1'b0, '0},   // byte before any packet, ignored
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},   // row 0, column 0
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b1, '{1'b0, 5'd0, 6'd0, 8'hFF, 8'h00, 8'h80, 1'b1, 1'b0}},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b0, '0},   // new packet drops the partial triple
		'{8'hFF, 1'b0, 1'b0, '0},   // row 63, column 16383
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'h56, 1'b0, 1'b1, '{1'b0, 5'd0, 6'd0, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1}},
		'{8'h40, 1'b1, 1'b0, '0},   // row 16
		'{8'h3F, 1'b0, 1'b0, '0},   // last column
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hA5, 1'b0, 1'b0, '0},
		'{8'h5A, 1'b0, 1'b0, '0},   //  red byte of the pixel at row 17, column 0
		'{8'hC3, 1'b0, 1'b0, '0},
		'{8'h7E, 1'b0, 1'b0, '0},
		'{8'hC0, 1'b1, 1'b0, '0},   // row 48, outside the frame
		'{8'h3F, 1'b0, 1'b0, '0},
		'{8'h11, 1'b0, 1'b0, '0},
		'{8'h22, 1'b0, 1'b0, '0},
		'{8'h33, 1'b0, 1'b1, '{1'b1, 5'd0, 6'd0, 8'h11, 8'h22, 8'h33, 1'b0, 1'b1}}
	};

	// parser copy
	phase_t      parse_state;
	logic [5:0]  scan_row;
	logic [13:0] scan_col;
	logic        fill_half;
	logic [7:0]  red_hold;
	logic [7:0]  green_hold;
	logic [7:0]  head_byte;

	pix_write_t pending_writes [$];
	int         mismatch_count;
	int         bytes_taken;
	int         cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit predict_pixel_write(input logic [7:0] value, input logic start,
			output pix_write_t w);
		logic [6:0]  next_row;
		logic [14:0] next_col;
		logic        inside_frame;
		w = '0;
		if (start) begin
			head_byte   = value;
			parse_state = PH_HDR1;
			return 1'b0;
		end
		case (parse_state)
			PH_HDR1: begin
				scan_row    = head_byte[7:2];
				scan_col    = {head_byte[5:0], value};
				parse_state = PH_RED;
				return 1'b0;
			end
			PH_RED: begin
				red_hold    = value;
				parse_state = PH_GREEN;
				return 1'b0;
			end
			PH_GREEN: begin
				green_hold  = value;
				parse_state = PH_BLUE;
				return 1'b0;
			end
			PH_BLUE: begin
				inside_frame    = (scan_row < NUM_ROWS) && (scan_col < NUM_COLUMNS);
				w.buffer_select = fill_half;
				w.pixel_row     = inside_frame ? scan_row[4:0] : '0;
				w.pixel_column  = inside_frame ? scan_col[5:0] : '0;
				w.red           = red_hold;
				w.green         = green_hold;
				w.blue          = value;
				w.pixel_valid   = inside_frame;
				w.frame_done    = 1'b0;
				next_col = {1'b0, scan_col} + 15'd1;
				next_row = {1'b0, scan_row};
				if (next_col >= NUM_COLUMNS) begin
					next_col = '0;
					next_row = next_row + 7'd1;
					// running past the last row closes the frame, even off-screen
					if (next_row >= NUM_ROWS) begin
						next_row     = '0;
						w.frame_done = 1'b1;
						fill_half    = ~fill_half;
					end
				end
				scan_row    = next_row[5:0];
				scan_col    = next_col[13:0];
				parse_state = PH_RED;
				return 1'b1;
			end
			default: begin
				parse_state = PH_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic offer_byte(input logic [7:0] value, input logic start, input bit typed,
			input pix_write_t typed_w);
		pix_write_t w;
		bit         made;
		bit         calm;
		calm = (bytes_taken >= 300) && (bytes_taken < 420);
		if (!calm && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		if (start || parse_state != PH_IDLE)
			bytes_taken++;
		made = predict_pixel_write(value, start, w);
		if (made)
			pending_writes.push_back(typed ? typed_w : w);
	endtask

	task automatic report_field(input string name, input int want, input int seen);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
		mismatch_count++;
	endtask

	task automatic check_write();
		pix_write_t got;
		pix_write_t want;
		got.buffer_select = m_axis_tuser[0];
		got.pixel_valid   = m_axis_tuser[1];
		got.frame_done    = m_axis_tlast;
		got.pixel_row     = m_axis_tdata[4:0];
		got.pixel_column  = m_axis_tdata[10:5];
		got.red           = m_axis_tdata[18:11];
		got.green         = m_axis_tdata[26:19];
		got.blue          = m_axis_tdata[34:27];
		if (pending_writes.size() == 0) begin
			$display("%0t: unexpected pixel write, expected none, actual %0h", $time, got);
			mismatch_count++;
		end else begin
			want = pending_writes.pop_front();
			if (got.buffer_select !== want.buffer_select)
				report_field("buffer_select", want.buffer_select, got.buffer_select);
			if (got.pixel_row !== want.pixel_row)
				report_field("pixel_row", want.pixel_row, got.pixel_row);
			if (got.pixel_column !== want.pixel_column)
				report_field("pixel_column", want.pixel_column, got.pixel_column);
			if (got.red !== want.red)
				report_field("red", want.red, got.red);
			if (got.green !== want.green)
				report_field("green", want.green, got.green);
			if (got.blue !== want.blue)
				report_field("blue", want.blue, got.blue);
			if (got.pixel_valid !== want.pixel_valid)
				report_field("pixel_valid", want.pixel_valid, got.pixel_valid);
			if (got.frame_done !== want.frame_done)
				report_field("frame_done", want.frame_done, got.frame_done);
		end
	endtask

	// write side: random stalls, one long hold-off, more random stalls, a stall-free stretch, then random stalls
	initial begin
		int hold_left;
		int writes_seen;
		bit held_once;
		hold_left   = 0;
		writes_seen = 0;
		held_once   = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				check_write();
				writes_seen++;
			end
			if (!held_once && writes_seen == 40) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (writes_seen >= 150 && writes_seen < 300) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 23);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [7:0] head;
		logic [7:0] tail;
		int         pick;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		parse_state    = PH_IDLE;
		scan_row       = '0;
		scan_col       = '0;
		fill_half      = 1'b0;
		red_hold       = '0;
		green_hold     = '0;
		head_byte      = '0;
		mismatch_count = 0;
		bytes_taken    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_byte(directed_rows[i].value, directed_rows[i].start,
				directed_rows[i].typed, directed_rows[i].write);

		while (bytes_taken < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				case ($urandom_range(0, 5))
					0:       head = 8'h00;
					1:       head = 8'h40;
					2:       head = 8'h80;
					3:       head = 8'hC0;
					default: head = 8'($urandom);
				endcase
				tail = $urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom);
				offer_byte(head, 1'b1, 1'b0, '0);
				offer_byte(tail, 1'b0, 1'b0, '0);
				repeat ($urandom_range(1, 12))
					repeat (3) offer_byte(8'($urandom), 1'b0, 1'b0, '0);
				// sometimes start a triple that a later header may cut short
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 2)) offer_byte(8'($urandom), 1'b0, 1'b0, '0);
			end else if (pick < 85) begin
				offer_byte(8'($urandom), 1'b1, 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 6))
					offer_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_writes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
